// ===== rtl/lsc_pkg.sv =====
// lsc_pkg: shared types and constants of the line segment clipper
// no dependencies
package lsc_pkg;

  localparam int COORD_W = 16;
  localparam int MAG_W   = COORD_W;
  localparam int DIV_W   = 2 * MAG_W;
  localparam int REM_W   = MAG_W;
  localparam int ADDR_W  = 4;

  localparam logic [3:0] CODE_LEFT   = 4'd1;
  localparam logic [3:0] CODE_RIGHT  = 4'd2;
  localparam logic [3:0] CODE_BOTTOM = 4'd4;
  localparam logic [3:0] CODE_TOP    = 4'd8;

  localparam logic [2:0] MAX_PASSES = 3'd4;

  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_RIGHT  = 2'd1;
  localparam logic [1:0] REG_BOTTOM = 2'd2;
  localparam logic [1:0] REG_TOP    = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_word_t;

  typedef struct packed {
    logic   accepted;
    coord_t clip_start_x;
    coord_t clip_start_y;
    coord_t clip_end_x;
    coord_t clip_end_y;
  } out_word_t;

  // word carried from one divider cell to the next
  typedef struct packed {
    logic             vld;
    logic [REM_W-1:0] rem;
    logic [DIV_W-1:0] num;
    logic [MAG_W-1:0] den;
  } div_cell_t;

endpackage

// ===== rtl/lsc_div_cell.sv =====
// lsc_div_cell: one restoring division step, registered
// depends on lsc_pkg
module lsc_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  lsc_pkg::div_cell_t  cell_in,
  output lsc_pkg::div_cell_t  cell_out
);
  import lsc_pkg::*;

  logic [REM_W:0]   trial;
  logic [REM_W:0]   diff;
  logic             qbit;
  div_cell_t        cell_nxt;
  div_cell_t        cell_r;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    trial    = {cell_in.rem, cell_in.num[DIV_W-1]};
    diff     = trial - {1'b0, cell_in.den};
    qbit     = (trial >= {1'b0, cell_in.den});
    cell_nxt = cell_in;
    cell_nxt.rem = qbit ? diff[REM_W-1:0] : trial[REM_W-1:0];
    cell_nxt.num = {cell_in.num[DIV_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else begin
      cell_r.vld <= cell_nxt.vld;
    end
    cell_r.rem <= cell_nxt.rem;
    cell_r.num <= cell_nxt.num;
    cell_r.den <= cell_nxt.den;
  end

  assign cell_out = cell_r;

endmodule

// ===== rtl/lsc_divider.sv =====
// lsc_divider: unsigned divider built as a row of division cells, one quotient bit per cell
// depends on lsc_pkg, lsc_div_cell
module lsc_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       div_start,
  input  logic [lsc_pkg::DIV_W-1:0]  dividend,
  input  logic [lsc_pkg::MAG_W-1:0]  divisor,
  output logic                       div_done,
  output logic [lsc_pkg::DIV_W-1:0]  quotient
);
  import lsc_pkg::*;

  div_cell_t chain [DIV_W+1];

  // head of the row
  always_comb begin
    chain[0].vld = div_start;
    chain[0].rem = '0;
    chain[0].num = dividend;
    chain[0].den = divisor;
  end

  for (genvar i = 0; i < DIV_W; i++) begin : g_cell
    lsc_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_in  (chain[i]),
      .cell_out (chain[i+1])
    );
  end

  assign div_done = chain[DIV_W].vld;
  assign quotient = chain[DIV_W].num;

endmodule

// ===== rtl/line_segment_clipper_unit.sv =====
// line_segment_clipper_unit: Cohen-Sutherland clipper top level with APB window registers
// depends on lsc_pkg, lsc_divider
//
// One segment is taken when start is high and busy is low. Each clipping pass
// that moves an endpoint steps through the multiply state, a launch state and
// a wait on the divider row (one quotient bit per cell), then updates the
// endpoint and recomputes the outcodes; a segment is decided after at most four moves.
// The result shows on out_word for exactly one cycle with out_valid and cannot
// be held off; busy drops in that same cycle. The user must write the window
// registers over the APB port only while busy is low; the block itself has no check for this.
module line_segment_clipper_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  lsc_pkg::in_word_t           in_word,
  output logic                        out_valid,
  output lsc_pkg::out_word_t          out_word,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [lsc_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import lsc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CODE, ST_DECIDE, ST_MUL, ST_DIV, ST_WAIT, ST_UPD
  } state_t;

  state_t            state_r;
  coord_t            win_l_r, win_r_r, win_b_r, win_t_r;
  coord_t            x0_r, y0_r, x1_r, y1_r;
  coord_t            px_r [2];
  coord_t            py_r [2];
  logic [3:0]        code_r [2];
  logic [2:0]        pass_r;
  logic              k_r;
  logic              horiz_r;
  logic              neg_r;
  logic              dzero_r;
  coord_t            base_r, edge_r;
  logic [MAG_W-1:0]  mag_a_r, mag_b_r, den_r;
  logic [DIV_W-1:0]  prod_r;
  logic              out_valid_r;
  out_word_t         out_word_r;

  logic              div_done;
  logic [DIV_W-1:0]  quot;

  // --- configuration port
  logic cfg_wr;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_l_r <= coord_t'(0);
      win_r_r <= coord_t'(639);
      win_b_r <= coord_t'(0);
      win_t_r <= coord_t'(479);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_LEFT:   win_l_r <= cfg_pwdata[COORD_W-1:0];
        REG_RIGHT:  win_r_r <= cfg_pwdata[COORD_W-1:0];
        REG_BOTTOM: win_b_r <= cfg_pwdata[COORD_W-1:0];
        REG_TOP:    win_t_r <= cfg_pwdata[COORD_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_LEFT:   cfg_prdata = 32'(win_l_r);
      REG_RIGHT:  cfg_prdata = 32'(win_r_r);
      REG_BOTTOM: cfg_prdata = 32'(win_b_r);
      REG_TOP:    cfg_prdata = 32'(win_t_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // --- outcodes of the current endpoints
  function automatic logic [3:0] outcode(coord_t x, coord_t y, coord_t l, coord_t r,
                                         coord_t b, coord_t t);
    logic [3:0] c;
    c = '0;
    if (x < l)      c = c | CODE_LEFT;
    else if (x > r) c = c | CODE_RIGHT;
    if (y < b)      c = c | CODE_BOTTOM;
    else if (y > t) c = c | CODE_TOP;
    return c;
  endfunction

  // --- edge selection for the next move
  logic             sel_k;
  logic [3:0]       sel_c;
  logic             sel_horiz;
  logic signed [COORD_W:0] num_a, num_b, num_c;
  coord_t           sel_edge, sel_base;
  logic             done_now;

  always_comb begin
    sel_k     = (code_r[0] != 4'd0) ? 1'b0 : 1'b1;
    sel_c     = code_r[sel_k];
    sel_horiz = 1'b0;
    sel_edge  = win_l_r;
    if ((sel_c & CODE_TOP) != 4'd0) begin
      sel_horiz = 1'b1;
      sel_edge  = win_t_r;
    end else if ((sel_c & CODE_BOTTOM) != 4'd0) begin
      sel_horiz = 1'b1;
      sel_edge  = win_b_r;
    end else if ((sel_c & CODE_RIGHT) != 4'd0) begin
      sel_edge  = win_r_r;
    end
    if (sel_horiz) begin
      num_a    = (COORD_W+1)'(x1_r) - (COORD_W+1)'(x0_r);
      num_c    = (COORD_W+1)'(y1_r) - (COORD_W+1)'(y0_r);
      num_b    = (COORD_W+1)'(sel_edge) - (COORD_W+1)'(y0_r);
      sel_base = x0_r;
    end else begin
      num_a    = (COORD_W+1)'(y1_r) - (COORD_W+1)'(y0_r);
      num_c    = (COORD_W+1)'(x1_r) - (COORD_W+1)'(x0_r);
      num_b    = (COORD_W+1)'(sel_edge) - (COORD_W+1)'(x0_r);
      sel_base = y0_r;
    end
    done_now = ((code_r[0] == 4'd0) && (code_r[1] == 4'd0)) ||
               ((code_r[0] & code_r[1]) != 4'd0) || (pass_r == MAX_PASSES);
  end

  function automatic logic [MAG_W-1:0] mag(logic signed [COORD_W:0] v);
    logic signed [COORD_W:0] a;
    a = v[COORD_W] ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  // --- moved coordinate: base plus signed quotient, saturated
  logic signed [DIV_W+1:0] q_s, sum_s;
  coord_t                  sat_v;
  localparam logic signed [DIV_W+1:0] SAT_HI = (DIV_W+2)'((1 << (COORD_W-1)) - 1);
  localparam logic signed [DIV_W+1:0] SAT_LO = -SAT_HI - 1;

  always_comb begin
    q_s = dzero_r ? '0 : $signed({2'b00, quot});
    if (neg_r) q_s = -q_s;
    sum_s = q_s + (DIV_W+2)'(base_r);
    if (sum_s > SAT_HI)      sat_v = coord_t'(SAT_HI);
    else if (sum_s < SAT_LO) sat_v = coord_t'(SAT_LO);
    else                     sat_v = sum_s[COORD_W-1:0];
  end

  lsc_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .div_start (state_r == ST_DIV),
    .dividend  (prod_r),
    .divisor   (den_r),
    .div_done  (div_done),
    .quotient  (quot)
  );

  // --- sequencer
  logic both_in;
  assign both_in = (code_r[0] == 4'd0) && (code_r[1] == 4'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (start) begin
          x0_r    <= in_word.start_x;
          y0_r    <= in_word.start_y;
          x1_r    <= in_word.end_x;
          y1_r    <= in_word.end_y;
          px_r[0] <= in_word.start_x;
          py_r[0] <= in_word.start_y;
          px_r[1] <= in_word.end_x;
          py_r[1] <= in_word.end_y;
          pass_r  <= '0;
          state_r <= ST_CODE;
        end
        ST_CODE: begin
          code_r[0] <= outcode(px_r[0], py_r[0], win_l_r, win_r_r, win_b_r, win_t_r);
          code_r[1] <= outcode(px_r[1], py_r[1], win_l_r, win_r_r, win_b_r, win_t_r);
          state_r   <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (done_now) begin
            out_valid_r             <= 1'b1;
            out_word_r.accepted     <= both_in;
            out_word_r.clip_start_x <= both_in ? px_r[0] : '0;
            out_word_r.clip_start_y <= both_in ? py_r[0] : '0;
            out_word_r.clip_end_x   <= both_in ? px_r[1] : '0;
            out_word_r.clip_end_y   <= both_in ? py_r[1] : '0;
            state_r                 <= ST_IDLE;
          end else begin
            k_r     <= sel_k;
            horiz_r <= sel_horiz;
            edge_r  <= sel_edge;
            base_r  <= sel_base;
            mag_a_r <= mag(num_a);
            mag_b_r <= mag(num_b);
            den_r   <= mag(num_c);
            dzero_r <= (num_c == '0);
            neg_r   <= num_a[COORD_W] ^ num_b[COORD_W] ^ num_c[COORD_W];
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r  <= DIV_W'(mag_a_r) * DIV_W'(mag_b_r);
          state_r <= ST_DIV;
        end
        ST_DIV:  state_r <= ST_WAIT;
        ST_WAIT: if (div_done) state_r <= ST_UPD;
        ST_UPD: begin
          if (horiz_r) begin
            px_r[k_r] <= sat_v;
            py_r[k_r] <= edge_r;
          end else begin
            px_r[k_r] <= edge_r;
            py_r[k_r] <= sat_v;
          end
          pass_r  <= pass_r + 3'd1;
          state_r <= ST_CODE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== rtl/lsc_checker.sv =====
// lsc_checker: port-level checks for the line segment clipper, bound to the top level
// depends on lsc_pkg, line_segment_clipper_unit
module lsc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input lsc_pkg::out_word_t out_word
);
  import lsc_pkg::*;

  // the result strobe is never held
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");

  // a taken word makes the block busy
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy missing after start");

  // the block only goes idle by delivering a result
  a_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid) else $error("busy dropped without result");

  // rejected segments carry zero endpoints
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.accepted) |->
      (out_word.clip_start_x == '0 && out_word.clip_start_y == '0 &&
       out_word.clip_end_x == '0 && out_word.clip_end_y == '0))
    else $error("rejected segment with nonzero endpoints");

endmodule

bind line_segment_clipper_unit lsc_checker u_lsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_word  (out_word)
);
